>>> rtl/cdt_pkg.sv
// Shared constants, types and the month table for the date to tick converter.
`default_nettype none
package cdt_pkg;

  localparam int unsigned STAGES        = 8;
  localparam int unsigned FIELD_W       = 16;
  localparam int unsigned USEC_W        = 32;
  localparam int unsigned TICK_W        = 64;

  localparam int unsigned DAYS_PER_YEAR = 365;
  localparam int unsigned HOURS_PER_DAY = 24;
  localparam int unsigned MIN_PER_HOUR  = 60;
  localparam int unsigned SEC_PER_MIN   = 60;
  localparam int unsigned USEC_PER_SEC  = 1000000;
  localparam int unsigned CENTURY       = 100;

  // floor(x / 100) = (x * RECIP_100) >> RECIP_SH, exact for every 16-bit x
  localparam int unsigned RECIP_100     = 83887;
  localparam int unsigned RECIP_SH      = 23;
  localparam int unsigned PROD_W        = 33;
  localparam int unsigned Q_W           = PROD_W - RECIP_SH;

  localparam int unsigned CUM_W         = 9;
  localparam int unsigned DAYS_W        = 25;
  localparam int unsigned HOUR_W        = 30;
  localparam int unsigned MIN_W         = 36;
  localparam int unsigned SEC_W         = 41;
  localparam int unsigned LO_W          = 21;
  localparam int unsigned HI_W          = SEC_W - LO_W;
  localparam int unsigned USEC_SCALE_W  = 20;
  localparam int unsigned PLO_W         = LO_W + USEC_SCALE_W;
  localparam int unsigned PHI_W         = HI_W + USEC_SCALE_W;

  typedef struct packed {
    logic [FIELD_W-1:0] hour;
    logic [FIELD_W-1:0] minute;
    logic [FIELD_W-1:0] second;
    logic [USEC_W-1:0]  microsecond;
  } clock_t;

  typedef logic [2:0] day_adv_t;

  function automatic logic [CUM_W-1:0] cum_days(input logic [3:0] m);
    logic [CUM_W-1:0] d;
    case (m)
      4'd1:    d = 9'd0;
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage
`default_nettype wire

>>> rtl/cdt_if.sv
// Valid/ready channel interfaces for the date input and the tick output.
`default_nettype none
interface cdt_date_if;
  logic        valid;
  logic        ready;
  logic [15:0] year;
  logic [15:0] month;
  logic [15:0] day;
  logic [15:0] hour;
  logic [15:0] minute;
  logic [15:0] second;
  logic [31:0] microsecond;

  modport source(output valid, year, month, day, hour, minute, second, microsecond,
                 input ready);
  modport sink(input valid, year, month, day, hour, minute, second, microsecond,
               output ready);
endinterface

interface cdt_tick_if;
  logic        valid;
  logic        ready;
  logic [63:0] tick;

  modport source(output valid, tick, input ready);
  modport sink(input valid, tick, output ready);
endinterface
`default_nettype wire

>>> rtl/cdt_days.sv
// Three-stage day count since 0001-01-01 from year, month and day.
`default_nettype none
module cdt_days
  import cdt_pkg::*;
(
  input  wire logic               clk,
  input  wire day_adv_t           adv,
  input  wire logic [FIELD_W-1:0] year,
  input  wire logic [FIELD_W-1:0] month,
  input  wire logic [FIELD_W-1:0] day,
  output logic      [DAYS_W-1:0]  days
);

  logic [FIELD_W-1:0] prior;
  logic [FIELD_W-1:0] prior_a;
  logic [FIELD_W-1:0] year_a;
  logic [PROD_W-1:0]  prior_prod;
  logic [PROD_W-1:0]  year_prod;
  logic [CUM_W-1:0]   cum_next;
  logic [CUM_W-1:0]   cum_a;
  logic               late_next;
  logic               late_a;
  logic [FIELD_W-1:0] dterm_a;

  logic [Q_W-1:0]     q_prior;
  logic [Q_W-1:0]     q_year;
  logic               century;
  logic               leap;
  logic [DAYS_W-1:0]  base_next;
  logic [DAYS_W-1:0]  base_b;
  logic [DAYS_W-1:0]  extra_b;

  always_comb begin
    prior     = (year == '0) ? '0 : year - FIELD_W'(1);
    cum_next  = '0;
    late_next = 1'b0;
    if (month inside {[16'd1:16'd12]}) begin
      cum_next  = cum_days(month[3:0]);
      late_next = (month inside {[16'd3:16'd12]});
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      prior_a    <= prior;
      year_a     <= year;
      prior_prod <= PROD_W'(prior) * PROD_W'(RECIP_100);
      year_prod  <= PROD_W'(year) * PROD_W'(RECIP_100);
      cum_a      <= cum_next;
      late_a     <= late_next;
      dterm_a    <= (day == '0) ? '0 : day - FIELD_W'(1);
    end
  end

  always_comb begin
    q_prior   = prior_prod[PROD_W-1:RECIP_SH];
    q_year    = year_prod[PROD_W-1:RECIP_SH];
    century   = (FIELD_W'(q_year) * FIELD_W'(CENTURY)) == year_a;
    leap      = (year_a[1:0] == 2'b00 && !century) || (century && q_year[1:0] == 2'b00);
    base_next = DAYS_W'(prior_a) * DAYS_W'(DAYS_PER_YEAR) + DAYS_W'(prior_a >> 2)
              - DAYS_W'(q_prior) + DAYS_W'(q_prior >> 2);
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      base_b  <= base_next;
      extra_b <= DAYS_W'(cum_a) + DAYS_W'(dterm_a) + DAYS_W'(late_a && leap);
    end
    if (adv[2]) begin
      days <= base_b + extra_b;
    end
  end

endmodule
`default_nettype wire

>>> rtl/civil_date_to_microsecond_tick_top.sv
// Top level: pipelined conversion of a civil date and time to a microsecond tick.
//
//   channel | dir | payload                                            | handshake
//   date    | in  | year month day hour minute second (16b) usec (32b) | valid/ready
//   stamp   | out | tick (64b)                                         | valid/ready
//
// Eight register stages; one item enters per cycle unless the stamp channel holds the pipeline.
// Stages 1-3 count days (reciprocal multiply for the century terms), 4-6 fold in
// hours, minutes and seconds, 7-8 scale by 1e6 as two partial products and add usec.
// Each stage holds while full and its successor holds; bubbles fill as items advance.
// Synchronous reset clears all stage valid bits; payload registers are not reset.
`default_nettype none
module civil_date_to_microsecond_tick_top
  import cdt_pkg::*;
(
  input wire logic    clk,
  input wire logic    rst,
  cdt_date_if.sink    date,
  cdt_tick_if.source  stamp
);

  logic [STAGES:1]   valid;
  logic [STAGES+1:1] load;
  clock_t            tm [1:STAGES-1];
  logic [DAYS_W-1:0] days;
  logic [HOUR_W-1:0] hours;
  logic [MIN_W-1:0]  mins;
  logic [SEC_W-1:0]  secs;
  logic [PLO_W-1:0]  prod_lo;
  logic [PHI_W-1:0]  prod_hi;
  logic [TICK_W-1:0] tick;

  always_comb begin
    load[STAGES+1] = stamp.ready;
    for (int k = STAGES; k >= 1; k--) begin
      load[k] = !valid[k] || load[k+1];
    end
  end

  assign date.ready  = load[1];
  assign stamp.valid = valid[STAGES];
  assign stamp.tick  = tick;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (load[1]) begin
        valid[1] <= date.valid;
      end
      for (int k = 2; k <= STAGES; k++) begin
        if (load[k]) begin
          valid[k] <= valid[k-1];
        end
      end
    end
  end

  cdt_days u_days (
    .clk  (clk),
    .adv  (load[3:1]),
    .year (date.year),
    .month(date.month),
    .day  (date.day),
    .days (days)
  );

  always_ff @(posedge clk) begin
    if (load[1]) begin
      tm[1] <= '{hour: date.hour, minute: date.minute, second: date.second,
                 microsecond: date.microsecond};
    end
    for (int k = 2; k < STAGES; k++) begin
      if (load[k]) begin
        tm[k] <= tm[k-1];
      end
    end
    if (load[4]) begin
      hours <= HOUR_W'(days) * HOUR_W'(HOURS_PER_DAY) + HOUR_W'(tm[3].hour);
    end
    if (load[5]) begin
      mins <= MIN_W'(hours) * MIN_W'(MIN_PER_HOUR) + MIN_W'(tm[4].minute);
    end
    if (load[6]) begin
      secs <= SEC_W'(mins) * SEC_W'(SEC_PER_MIN) + SEC_W'(tm[5].second);
    end
    if (load[7]) begin
      prod_lo <= PLO_W'(secs[LO_W-1:0]) * PLO_W'(USEC_PER_SEC);
      prod_hi <= PHI_W'(secs[SEC_W-1:LO_W]) * PHI_W'(USEC_PER_SEC);
    end
    if (load[8]) begin
      tick <= TICK_W'(prod_lo) + (TICK_W'(prod_hi) << LO_W) + TICK_W'(tm[7].microsecond);
    end
  end

endmodule
`default_nettype wire

>>> rtl/cdt_checker.sv
// Port-level assertions for the converter, bound to the top level.
`default_nettype none
module cdt_checker
  import cdt_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [TICK_W-1:0] tick
);

  logic [3:0] count;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count + 4'(in_acc) - 4'(out_acc);
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(tick))
    else $error("stalled tick changed or dropped");

  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input held off without an output stall");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> count != 4'd0)
    else $error("tick shown with no item in flight");

  a_bound: assert property (@(posedge clk) disable iff (rst)
    count <= 4'(STAGES))
    else $error("more items in flight than stages");

endmodule

bind civil_date_to_microsecond_tick_top cdt_checker u_cdt_checker (
  .clk      (clk),
  .rst      (rst),
  .in_valid (date.valid),
  .in_ready (date.ready),
  .out_valid(stamp.valid),
  .out_ready(stamp.ready),
  .tick     (stamp.tick)
);
`default_nettype wire

>>> bench/testbench.sv
// Testbench for the civil date to microsecond tick converter: directed and random dates.
`timescale 1ns / 100ps
`default_nettype none
module testbench;
  import cdt_pkg::*;

  localparam int unsigned IDLE_LIMIT = 5000;
  localparam int unsigned LONG_STALL = 200;
  localparam int unsigned TAIL_CYCLES = 3 * STAGES;

  typedef struct {
    logic [FIELD_W-1:0] year;
    logic [FIELD_W-1:0] month;
    logic [FIELD_W-1:0] day;
    logic [FIELD_W-1:0] hour;
    logic [FIELD_W-1:0] minute;
    logic [FIELD_W-1:0] second;
    logic [USEC_W-1:0]  microsecond;
  } civil_date_t;

  logic clk;
  logic rst;

  cdt_date_if date_ch();
  cdt_tick_if stamp_ch();

  civil_date_to_microsecond_tick_top dut (
    .clk   (clk),
    .rst   (rst),
    .date  (date_ch),
    .stamp (stamp_ch)
  );

  logic [TICK_W-1:0] pending_ticks[$];
  int unsigned mismatches = 0;
  int unsigned src_gap_max = 0;
  int unsigned sink_gap_max = 0;
  int unsigned sink_hold = 0;

  int unsigned month_start[13] = '{0, 0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

  function automatic logic [TICK_W-1:0] tick_of_date(civil_date_t d);
    logic [63:0] prior;
    logic [63:0] days;
    logic [63:0] t;
    logic        leap;
    prior = (d.year != 0) ? 64'(d.year) - 64'd1 : 64'd0;
    days  = prior * 64'd365 + prior / 64'd4 - prior / 64'd100 + prior / 64'd400;
    leap  = ((d.year % 16'd4) == 0 && (d.year % 16'd100) != 0) || (d.year % 16'd400) == 0;
    if (d.month >= 1 && d.month <= 12) begin
      days += 64'(month_start[d.month[3:0]]);
      if (d.month > 2 && leap) begin
        days += 64'd1;
      end
    end
    if (d.day != 0) begin
      days += 64'(d.day) - 64'd1;
    end
    t = ((days * 64'd24 + 64'(d.hour)) * 64'd60 + 64'(d.minute)) * 64'd60 + 64'(d.second);
    t = t * 64'd1000000 + 64'(d.microsecond);
    return t;
  endfunction

  function automatic civil_date_t mk_date(int unsigned y, int unsigned mo, int unsigned d,
                                          int unsigned h, int unsigned mi, int unsigned s,
                                          int unsigned us);
    civil_date_t r;
    r.year = y[15:0];
    r.month = mo[15:0];
    r.day = d[15:0];
    r.hour = h[15:0];
    r.minute = mi[15:0];
    r.second = s[15:0];
    r.microsecond = us;
    return r;
  endfunction

  function automatic civil_date_t calendar_date();
    return mk_date($urandom_range(0, 9) == 0 ? $urandom_range(0, 65535) : $urandom_range(1, 9999),
                   $urandom_range(1, 12), $urandom_range(1, 31), $urandom_range(0, 23),
                   $urandom_range(0, 59), $urandom_range(0, 59), $urandom_range(0, 999999));
  endfunction

  function automatic civil_date_t raw_date();
    return mk_date($urandom_range(0, 65535), $urandom_range(0, 65535), $urandom_range(0, 65535),
                   $urandom_range(0, 65535), $urandom_range(0, 65535), $urandom_range(0, 65535),
                   $urandom());
  endfunction

  function automatic civil_date_t mixed_date();
    return ($urandom_range(0, 3) == 0) ? raw_date() : calendar_date();
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic offer_date(civil_date_t d);
    int unsigned gap;
    gap = $urandom_range(0, src_gap_max);
    @(negedge clk);
    if (gap > 0) begin
      date_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    date_ch.valid       <= 1'b1;
    date_ch.year        <= d.year;
    date_ch.month       <= d.month;
    date_ch.day         <= d.day;
    date_ch.hour        <= d.hour;
    date_ch.minute      <= d.minute;
    date_ch.second      <= d.second;
    date_ch.microsecond <= d.microsecond;
    do @(posedge clk); while (!date_ch.ready);
    pending_ticks.push_back(tick_of_date(d));
  endtask

  task automatic release_date();
    @(negedge clk);
    date_ch.valid <= 1'b0;
  endtask

  task automatic wait_drain();
    release_date();
    while (pending_ticks.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    civil_date_t d;
    src_gap_max = 3;
    sink_gap_max = 3;
    offer_date(mk_date(0, 0, 0, 0, 0, 0, 0));
    offer_date(mk_date(1, 1, 1, 0, 0, 0, 0));
    offer_date(mk_date(65535, 65535, 65535, 65535, 65535, 65535, 32'hFFFF_FFFF));
    offer_date(mk_date(65535, 12, 31, 23, 59, 59, 999999));
    offer_date(mk_date(0, 3, 1, 0, 0, 0, 0));
    offer_date(mk_date(1900, 3, 1, 0, 0, 0, 0));
    offer_date(mk_date(2024, 2, 29, 12, 0, 0, 1));
    offer_date(mk_date(2023, 13, 5, 1, 2, 3, 4));
    offer_date(mk_date(2020, 0, 0, 0, 0, 0, 0));
    offer_date(mk_date(1970, 1, 1, 100, 1000, 65535, 0));
    offer_date(mk_date(400, 12, 31, 0, 0, 0, 32'hFFFF_FFFF));
    offer_date(mk_date(32768, 32768, 32768, 32768, 32768, 32768, 32'h8000_0000));
    for (int m = 1; m <= 12; m++) begin
      d = mk_date(2000, m, 15, 6, 30, 30, 500000);
      offer_date(d);
    end
    wait_drain();
  endtask

  task automatic test_random_calendar(int unsigned count);
    src_gap_max = 10;
    sink_gap_max = 10;
    for (int unsigned i = 0; i < count; i++) begin
      offer_date(calendar_date());
    end
  endtask

  task automatic test_random_raw(int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      if (i % 50 == 0) begin
        src_gap_max = $urandom_range(0, 10);
        sink_gap_max = $urandom_range(0, 10);
      end
      offer_date(raw_date());
    end
  endtask

  task automatic test_streaming(int unsigned count);
    src_gap_max = 0;
    sink_gap_max = 0;
    for (int unsigned i = 0; i < count; i++) begin
      offer_date(mixed_date());
    end
  endtask

  task automatic test_backpressure(int unsigned count);
    src_gap_max = 0;
    sink_gap_max = 2;
    sink_hold = LONG_STALL;
    for (int unsigned i = 0; i < count; i++) begin
      offer_date(mixed_date());
    end
    wait_drain();
  endtask

  task automatic test_drain_pause(int unsigned bursts, int unsigned burst_len);
    src_gap_max = 4;
    sink_gap_max = 4;
    for (int unsigned b = 0; b < bursts; b++) begin
      for (int unsigned i = 0; i < burst_len; i++) begin
        offer_date(mixed_date());
      end
      wait_drain();
    end
  endtask

  initial begin
    int unsigned hold;
    stamp_ch.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (sink_hold > 0) begin
        hold = sink_hold;
        sink_hold = 0;
      end else begin
        hold = $urandom_range(0, sink_gap_max);
      end
      @(negedge clk);
      if (hold > 0) begin
        stamp_ch.ready <= 1'b0;
        repeat (hold) @(negedge clk);
      end
      stamp_ch.ready <= 1'b1;
      do @(posedge clk); while (!stamp_ch.valid);
    end
  end

  always @(posedge clk) begin
    logic [TICK_W-1:0] want;
    if (!rst && stamp_ch.valid && stamp_ch.ready) begin
      if (pending_ticks.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected tick %h at %0t", stamp_ch.tick, $realtime);
        end
      end else begin
        want = pending_ticks.pop_front();
        if (stamp_ch.tick !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("tick mismatch at %0t: expected %h, got %h", $realtime, want,
                     stamp_ch.tick);
          end
        end
      end
    end
  end

  initial begin
    int unsigned idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((date_ch.valid && date_ch.ready) || (stamp_ch.valid && stamp_ch.ready)) begin
        idle = 0;
      end else begin
        idle++;
      end
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    rst = 1'b1;
    date_ch.valid = 1'b0;
    date_ch.year = '0;
    date_ch.month = '0;
    date_ch.day = '0;
    date_ch.hour = '0;
    date_ch.minute = '0;
    date_ch.second = '0;
    date_ch.microsecond = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_random_calendar(700);
    test_random_raw(400);
    test_streaming(300);
    test_backpressure(60);
    test_drain_pause(4, 25);

    wait_drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_ticks.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
`default_nettype wire
